@@ hdl/brtc_pkg.sv @@
// Package for the belief-ranked top-k cache: sizes, codes, transaction and
// controller/datapath command types. No dependencies.
`default_nettype none
package brtc_pkg;
   localparam int CACHE_DEPTH = 16;
   localparam int BATCH_DEPTH = 16;
   localparam int TABLE_DEPTH = CACHE_DEPTH + BATCH_DEPTH;
   localparam int MEM_DEPTH   = 2 * TABLE_DEPTH;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ID_W        = 64;
   localparam int BEL_W       = 16;
   localparam int HIT_W       = 16;
   localparam int CAP_W       = 5;
   localparam int TOT_W       = 32;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_KEEP   = 2'd1;
   localparam logic [1:0] KIND_EVICT  = 2'd2;

   localparam logic ACT_MERGE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ID_W-1:0]   item_id;
      logic [BEL_W-1:0]  belief;
      logic [HIT_W-1:0]  initial_hits;
      logic              count_hit;
      logic              batch_last;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ID_W-1:0]   out_id;
      logic [BEL_W-1:0]  out_belief;
      logic [HIT_W-1:0]  out_hits;
      logic              found;
      logic              last_of_run;
      logic [TOT_W-1:0]  unused_count;
      logic [TOT_W-1:0]  insertion_count;
   } rsp_type;

   typedef struct packed {
      logic             latch;
      logic             rd_en;
      logic             rd_sorted;
      logic [IDX_W-1:0] rd_idx;
      logic             proc_scan;
      logic             proc_sort;
      logic             best_clr;
      logic             look_load;
      logic             merge_wr;
      logic             sort_start;
      logic             place;
      logic [IDX_W-1:0] rank;
      logic             count_apply;
      logic             list_load;
      logic             finish;
   } cmd_type;

   typedef struct packed {
      logic             is_lookup;
      logic             batch_last;
      logic [CNT_W-1:0] count;
      logic             list_emit;
      logic             out_busy;
   } status_type;
endpackage
`default_nettype wire

@@ hdl/brtc_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on brtc_pkg.
`default_nettype none
interface brtc_req_if;
   logic              valid;
   logic              ready;
   brtc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface brtc_rsp_if;
   logic              valid;
   logic              ready;
   brtc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/brtc_ctrl.sv @@
// Sequencer for the cache: scans, selection sort passes and listing.
// Depends on brtc_pkg; drives brtc_datapath through cmd_type.
`default_nettype none
module brtc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire brtc_pkg::status_type stat,
   output brtc_pkg::cmd_type         cmd
);
   import brtc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_LOOK_OUT, S_MERGE_WR, S_SORT_INIT, S_SORT_SCAN,
      S_PLACE, S_COUNT, S_LIST_RD, S_LIST_EMIT, S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] k_next, r_next;

   assign k_next = CNT_W'(k_ff + 1'b1);
   assign r_next = CNT_W'(r_ff + 1'b1);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch    = 1'b1;
               cmd.best_clr = 1'b1;
               k_in         = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en     = (k_ff < stat.count);
            cmd.rd_idx    = k_ff[IDX_W-1:0];
            cmd.proc_scan = (k_ff != '0);
            if (k_ff == stat.count) begin
               state_in = stat.is_lookup ? S_LOOK_OUT : S_MERGE_WR;
            end else begin
               k_in = k_next;
            end
         end
         S_LOOK_OUT: begin
            if (!stat.out_busy) begin
               cmd.look_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            state_in     = stat.batch_last ? S_SORT_INIT : S_IDLE;
         end
         S_SORT_INIT: begin
            cmd.sort_start = 1'b1;
            r_in           = '0;
            k_in           = '0;
            state_in       = S_SORT_SCAN;
         end
         S_SORT_SCAN: begin
            cmd.rd_en     = (k_ff < stat.count);
            cmd.rd_idx    = k_ff[IDX_W-1:0];
            cmd.proc_sort = (k_ff != '0);
            cmd.best_clr  = (k_ff == '0);
            if (k_ff == stat.count) begin
               state_in = S_PLACE;
            end else begin
               k_in = k_next;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            cmd.rank  = r_ff[IDX_W-1:0];
            k_in      = '0;
            if (r_next == stat.count) begin
               state_in = S_COUNT;
            end else begin
               r_in     = r_next;
               state_in = S_SORT_SCAN;
            end
         end
         S_COUNT: begin
            cmd.count_apply = 1'b1;
            k_in            = '0;
            state_in        = S_LIST_RD;
         end
         S_LIST_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sorted = 1'b1;
            cmd.rd_idx    = k_ff[IDX_W-1:0];
            state_in      = S_LIST_EMIT;
         end
         S_LIST_EMIT: begin
            cmd.rank = k_ff[IDX_W-1:0];
            if (!stat.list_emit || !stat.out_busy) begin
               cmd.list_load = stat.list_emit;
               if (k_next == stat.count) begin
                  state_in = S_FINISH;
               end else begin
                  k_in     = k_next;
                  state_in = S_LIST_RD;
               end
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         r_ff     <= r_in;
      end
   end

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SORT_SCAN) |-> k_ff <= stat.count)
      else $error("scan index past table count");
   a_place_rank: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> r_ff < stat.count)
      else $error("sort rank past table count");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> state_ff == S_SCAN)
      else $error("accepted transaction did not start a scan");
endmodule
`default_nettype wire

@@ hdl/brtc_datapath.sv @@
// Table memories, match/sort registers, counters and response register.
// Depends on brtc_pkg; commanded by brtc_ctrl.
`default_nettype none
module brtc_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire brtc_pkg::cmd_type           cmd,
   output brtc_pkg::status_type             stat,
   input  wire brtc_pkg::req_type           req_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [brtc_pkg::CAP_W-1:0]  csr_wr_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output brtc_pkg::rsp_type                rsp_data
);
   import brtc_pkg::*;

   logic [ID_W-1:0]  id_mem  [MEM_DEPTH];
   logic [BEL_W-1:0] bel_mem [MEM_DEPTH];
   logic [HIT_W-1:0] hit_mem [MEM_DEPTH];
   logic             cch_mem [MEM_DEPTH];

   logic             bank_ff;
   logic [CNT_W-1:0] count_ff, base_ff;
   logic [CAP_W-1:0] capacity_ff;
   req_type          req_ff;
   logic             found_ff;
   logic [IDX_W-1:0] fidx_ff;
   logic [BEL_W-1:0] fbel_ff;
   logic [HIT_W-1:0] fhit_ff;
   logic             have_ff;
   logic [IDX_W-1:0] bidx_ff;
   logic [ID_W-1:0]  bid_ff;
   logic [BEL_W-1:0] bbel_ff;
   logic [HIT_W-1:0] bhit_ff;
   logic             bcch_ff;
   logic [TABLE_DEPTH-1:0] picked_ff;
   logic [CNT_W-1:0] ins_acc_ff, unu_acc_ff, evc_acc_ff, emit_cnt_ff;
   logic [TOT_W-1:0] unused_ff, insert_ff;
   logic [ID_W-1:0]  rd_id_ff;
   logic [BEL_W-1:0] rd_bel_ff;
   logic [HIT_W-1:0] rd_hit_ff;
   logic             rd_cch_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [CNT_W-1:0] cap_raw, cap;
   logic             out_busy;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic             we_id, we_bel, we_hit, we_cch;
   logic [ID_W-1:0]  wd_id;
   logic [BEL_W-1:0] wd_bel;
   logic [HIT_W-1:0] wd_hit;
   logic             wd_cch;
   logic             scan_match, rank_keep;
   logic [HIT_W-1:0] hits_new;
   logic [TOT_W:0]   ins_sum, unu_sum;
   logic             load;
   rsp_type          load_data;

   always_comb begin
      cap_raw = (capacity_ff == '0) ? CNT_W'(1) : CNT_W'(capacity_ff);
      if (cap_raw > CNT_W'(CACHE_DEPTH)) cap_raw = CNT_W'(CACHE_DEPTH);
      cap = (cap_raw > count_ff) ? count_ff : cap_raw;
   end

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign rd_addr   = {cmd.rd_sorted ? ~bank_ff : bank_ff, cmd.rd_idx};
   assign rank_keep = CNT_W'(cmd.rank) < cap;
   assign scan_match = cmd.proc_scan && !found_ff && (rd_id_ff == req_ff.item_id) &&
                       (req_ff.action == ACT_MERGE || CNT_W'(rd_idx_ff) < base_ff);
   assign hits_new  = (req_ff.count_hit && fhit_ff != '1) ? HIT_W'(fhit_ff + 1'b1) : fhit_ff;
   assign ins_sum   = {1'b0, insert_ff} + (TOT_W+1)'(ins_acc_ff);
   assign unu_sum   = {1'b0, unused_ff} + (TOT_W+1)'(unu_acc_ff);

   assign stat.is_lookup  = (req_ff.action == ACT_LOOKUP);
   assign stat.batch_last = req_ff.batch_last;
   assign stat.count      = count_ff;
   assign stat.list_emit  = rank_keep || rd_cch_ff;
   assign stat.out_busy   = out_busy;

   always_comb begin
      wr_addr = {bank_ff, fidx_ff};
      we_id = 1'b0; we_bel = 1'b0; we_hit = 1'b0; we_cch = 1'b0;
      wd_id = req_ff.item_id; wd_bel = req_ff.belief;
      wd_hit = req_ff.initial_hits; wd_cch = 1'b0;
      if (cmd.merge_wr) begin
         if (found_ff) begin
            we_bel = 1'b1;
         end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
            wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
            we_id = 1'b1; we_bel = 1'b1; we_hit = 1'b1; we_cch = 1'b1;
         end
      end else if (cmd.look_load) begin
         wd_hit = hits_new;
         we_hit = found_ff && req_ff.count_hit;
      end else if (cmd.place) begin
         wr_addr = {~bank_ff, cmd.rank};
         wd_id = bid_ff; wd_bel = bbel_ff; wd_hit = bhit_ff; wd_cch = bcch_ff;
         we_id = 1'b1; we_bel = 1'b1; we_hit = 1'b1; we_cch = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we_id)  id_mem[wr_addr]  <= wd_id;
      if (we_bel) bel_mem[wr_addr] <= wd_bel;
      if (we_hit) hit_mem[wr_addr] <= wd_hit;
      if (we_cch) cch_mem[wr_addr] <= wd_cch;
      if (cmd.rd_en) begin
         rd_id_ff  <= id_mem[rd_addr];
         rd_bel_ff <= bel_mem[rd_addr];
         rd_hit_ff <= hit_mem[rd_addr];
         rd_cch_ff <= cch_mem[rd_addr];
         rd_idx_ff <= cmd.rd_idx;
      end
   end

   always_comb begin
      load      = cmd.look_load || cmd.list_load;
      load_data = '0;
      load_data.unused_count    = unused_ff;
      load_data.insertion_count = insert_ff;
      if (cmd.look_load) begin
         load_data.kind        = KIND_LOOKUP;
         load_data.out_id      = req_ff.item_id;
         load_data.out_belief  = found_ff ? fbel_ff : '0;
         load_data.out_hits    = found_ff ? hits_new : '0;
         load_data.found       = found_ff;
         load_data.last_of_run = 1'b1;
      end else begin
         load_data.kind        = rank_keep ? KIND_KEEP : KIND_EVICT;
         load_data.out_id      = rd_id_ff;
         load_data.out_belief  = rd_bel_ff;
         load_data.out_hits    = rd_hit_ff;
         load_data.last_of_run = (CNT_W'(emit_cnt_ff + 1'b1) == CNT_W'(cap + evc_acc_ff));
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
      if (scan_match) begin
         fidx_ff <= rd_idx_ff;
         fbel_ff <= rd_bel_ff;
         fhit_ff <= rd_hit_ff;
      end
      if (cmd.proc_sort && !picked_ff[rd_idx_ff] && (!have_ff || rd_bel_ff > bbel_ff)) begin
         bidx_ff <= rd_idx_ff;
         bid_ff  <= rd_id_ff;
         bbel_ff <= rd_bel_ff;
         bhit_ff <= rd_hit_ff;
         bcch_ff <= CNT_W'(rd_idx_ff) < base_ff;
      end
      if (load) rsp_ff <= load_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         base_ff      <= '0;
         capacity_ff  <= CAP_W'(CACHE_DEPTH);
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
         picked_ff    <= '0;
         ins_acc_ff   <= '0;
         unu_acc_ff   <= '0;
         evc_acc_ff   <= '0;
         emit_cnt_ff  <= '0;
         unused_ff    <= '0;
         insert_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) capacity_ff <= csr_wr_data;
         if (cmd.latch) found_ff <= 1'b0;
         else if (scan_match) found_ff <= 1'b1;
         if (cmd.merge_wr && !found_ff && count_ff < CNT_W'(TABLE_DEPTH))
            count_ff <= CNT_W'(count_ff + 1'b1);
         if (cmd.best_clr) have_ff <= 1'b0;
         else if (cmd.proc_sort && !picked_ff[rd_idx_ff]) have_ff <= 1'b1;
         if (cmd.sort_start) begin
            picked_ff   <= '0;
            ins_acc_ff  <= '0;
            unu_acc_ff  <= '0;
            evc_acc_ff  <= '0;
            emit_cnt_ff <= '0;
         end
         if (cmd.place) begin
            picked_ff[bidx_ff] <= 1'b1;
            if (rank_keep && !bcch_ff) ins_acc_ff <= CNT_W'(ins_acc_ff + 1'b1);
            if (!rank_keep && bcch_ff) begin
               evc_acc_ff <= CNT_W'(evc_acc_ff + 1'b1);
               if (bhit_ff == '0) unu_acc_ff <= CNT_W'(unu_acc_ff + 1'b1);
            end
         end
         if (cmd.count_apply) begin
            insert_ff <= ins_sum[TOT_W] ? '1 : ins_sum[TOT_W-1:0];
            unused_ff <= unu_sum[TOT_W] ? '1 : unu_sum[TOT_W-1:0];
         end
         if (cmd.list_load) emit_cnt_ff <= CNT_W'(emit_cnt_ff + 1'b1);
         if (cmd.finish) begin
            bank_ff  <= ~bank_ff;
            count_ff <= cap;
            base_ff  <= cap;
         end
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH) && base_ff <= count_ff)
      else $error("table count out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !out_busy)
      else $error("response register overwritten while held");
   a_finish_trim: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> count_ff <= CNT_W'(CACHE_DEPTH) && count_ff != '0)
      else $error("retained count out of range after batch");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> emit_cnt_ff == CNT_W'(cap + evc_acc_ff))
      else $error("listing count mismatch at batch end");
endmodule
`default_nettype wire

@@ hdl/belief_ranked_topk_cache_core.sv @@
// Top level of the belief-ranked top-k cache: controller plus datapath.
// Depends on brtc_pkg, brtc_if, brtc_ctrl, brtc_datapath.
//
//  channel  dir  handshake            payload
//  req_if   in   valid/ready          brtc_pkg::req_type
//  rsp_if   out  valid/ready          brtc_pkg::rsp_type
//  csr      in   csr_wr_en            csr_wr_data (capacity)
//
// One transaction at a time; a lookup or non-final candidate scans all n table
// entries with one memory read per entry. A batch end adds a selection sort,
// then a listing pass that reads each table entry in sorted order, and a
// finish step.
// Synchronous active-high reset empties the table; no clearing pass.
// A held response stalls lookups and listing; no request is taken meanwhile.
`default_nettype none
module belief_ranked_topk_cache_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   brtc_req_if.sink                         req_if,
   brtc_rsp_if.source                       rsp_if,
   input  wire logic                        csr_wr_en,
   input  wire logic [brtc_pkg::CAP_W-1:0]  csr_wr_data
);
   import brtc_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       req_ready;
   logic       rsp_valid;
   rsp_type    rsp_data;

   brtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brtc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_if.data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_data)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign rsp_if.data  = rsp_data;
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for belief_ranked_topk_cache_core: directed tests then
// random merge batches and lookups against a behavioral cache predictor.
// Depends on brtc_pkg, brtc_if and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import brtc_pkg::*;

   localparam int TABLE_SIZE = CACHE_DEPTH + BATCH_DEPTH;
   localparam int IDLE_WAIT  = 1400;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   brtc_req_if req_if ();
   brtc_rsp_if rsp_if ();

   belief_ranked_topk_cache_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // cache predictor state
   logic [ID_W-1:0]  tbl_id     [TABLE_SIZE];
   logic [BEL_W-1:0] tbl_belief [TABLE_SIZE];
   logic [HIT_W-1:0] tbl_hits   [TABLE_SIZE];
   logic             tbl_cached [TABLE_SIZE];
   int               tbl_count;
   logic [TOT_W-1:0] unused_total;
   logic [TOT_W-1:0] insert_total;
   logic [CAP_W-1:0] capacity;

   rsp_type expected_rsp [$];
   int errors;
   int items_sent;
   logic [ID_W-1:0] id_pool [24];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [ID_W-1:0] id,
                                        logic [BEL_W-1:0] bel, logic [HIT_W-1:0] hits,
                                        logic found);
      rsp_type r;
      r.kind = kind;
      r.out_id = id;
      r.out_belief = bel;
      r.out_hits = hits;
      r.found = found;
      r.last_of_run = 1'b0;
      r.unused_count = unused_total;
      r.insertion_count = insert_total;
      return r;
   endfunction

   function automatic void expect_rsp(input rsp_type r);
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   task automatic predict_cache(input req_type r);
      logic hit_found;
      int n;
      int cap;
      int j;
      logic [ID_W-1:0] t_id;
      logic [BEL_W-1:0] t_bel;
      logic [HIT_W-1:0] t_hits;
      logic t_cached;
      rsp_type res;
      rsp_type batch_out [$];
      hit_found = 1'b0;
      if (r.action == ACT_LOOKUP) begin
         for (int i = 0; i < tbl_count; i++) begin
            if (!hit_found && tbl_cached[i] && tbl_id[i] == r.item_id) begin
               hit_found = 1'b1;
               if (r.count_hit && tbl_hits[i] != '1)
                  tbl_hits[i]++;
               res = make_rsp(KIND_LOOKUP, r.item_id, tbl_belief[i], tbl_hits[i], 1'b1);
            end
         end
         if (!hit_found)
            res = make_rsp(KIND_LOOKUP, r.item_id, '0, '0, 1'b0);
         res.last_of_run = 1'b1;
         expect_rsp(res);
         return;
      end
      for (int i = 0; i < tbl_count; i++) begin
         if (!hit_found && tbl_id[i] == r.item_id) begin
            tbl_belief[i] = r.belief;
            hit_found = 1'b1;
         end
      end
      if (!hit_found && tbl_count < TABLE_SIZE) begin
         tbl_id[tbl_count] = r.item_id;
         tbl_belief[tbl_count] = r.belief;
         tbl_hits[tbl_count] = r.initial_hits;
         tbl_cached[tbl_count] = 1'b0;
         tbl_count++;
      end
      if (!r.batch_last)
         return;
      n = tbl_count;
      for (int i = 1; i < n; i++) begin
         t_id = tbl_id[i];
         t_bel = tbl_belief[i];
         t_hits = tbl_hits[i];
         t_cached = tbl_cached[i];
         j = i;
         while (j > 0 && tbl_belief[j-1] < t_bel) begin
            tbl_id[j] = tbl_id[j-1];
            tbl_belief[j] = tbl_belief[j-1];
            tbl_hits[j] = tbl_hits[j-1];
            tbl_cached[j] = tbl_cached[j-1];
            j--;
         end
         tbl_id[j] = t_id;
         tbl_belief[j] = t_bel;
         tbl_hits[j] = t_hits;
         tbl_cached[j] = t_cached;
      end
      cap = capacity;
      if (cap < 1) cap = 1;
      if (cap > CACHE_DEPTH) cap = CACHE_DEPTH;
      if (cap > n) cap = n;
      for (int i = 0; i < cap; i++)
         if (!tbl_cached[i] && insert_total != '1) insert_total++;
      for (int i = cap; i < n; i++)
         if (tbl_cached[i] && tbl_hits[i] == 0 && unused_total != '1) unused_total++;
      for (int i = 0; i < cap; i++)
         batch_out.insert(batch_out.size(),
                          make_rsp(KIND_KEEP, tbl_id[i], tbl_belief[i], tbl_hits[i], 1'b0));
      for (int i = cap; i < n; i++)
         if (tbl_cached[i])
            batch_out.insert(batch_out.size(),
                             make_rsp(KIND_EVICT, tbl_id[i], tbl_belief[i],
                                      tbl_hits[i], 1'b0));
      if (batch_out.size() > 0)
         batch_out[batch_out.size()-1].last_of_run = 1'b1;
      foreach (batch_out[i])
         expect_rsp(batch_out[i]);
      for (int i = 0; i < TABLE_SIZE; i++)
         tbl_cached[i] = (i < cap);
      tbl_count = cap;
   endtask

   // response side: random backpressure, mostly short, occasionally long
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 3);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected transaction: kind %0d id %h", rsp_if.data.kind,
                        rsp_if.data.out_id);
         end else begin
            exp_r = expected_rsp.pop_front();
            if (rsp_if.data.kind !== exp_r.kind ||
                rsp_if.data.out_id !== exp_r.out_id ||
                rsp_if.data.out_belief !== exp_r.out_belief ||
                rsp_if.data.out_hits !== exp_r.out_hits ||
                rsp_if.data.found !== exp_r.found ||
                rsp_if.data.last_of_run !== exp_r.last_of_run ||
                rsp_if.data.unused_count !== exp_r.unused_count ||
                rsp_if.data.insertion_count !== exp_r.insertion_count) begin
               errors++;
               if (errors <= 10) begin
                  $display({"Mismatch exp: kind %0d id %h bel %h hits %h found %b",
                            " last %b unused %0d ins %0d"},
                           exp_r.kind, exp_r.out_id, exp_r.out_belief, exp_r.out_hits,
                           exp_r.found, exp_r.last_of_run, exp_r.unused_count,
                           exp_r.insertion_count);
                  $display({"         got: kind %0d id %h bel %h hits %h found %b",
                            " last %b unused %0d ins %0d"},
                           rsp_if.data.kind, rsp_if.data.out_id, rsp_if.data.out_belief,
                           rsp_if.data.out_hits, rsp_if.data.found, rsp_if.data.last_of_run,
                           rsp_if.data.unused_count, rsp_if.data.insertion_count);
               end
            end
         end
      end
   end

   task automatic send_item(input req_type r);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      predict_cache(r);
      items_sent++;
   endtask

   task automatic send_merge(input logic [ID_W-1:0] id, input logic [BEL_W-1:0] bel,
                             input logic [HIT_W-1:0] hits, input logic last);
      req_type r;
      r.action = ACT_MERGE;
      r.item_id = id;
      r.belief = bel;
      r.initial_hits = hits;
      r.count_hit = 1'($urandom_range(0, 1));
      r.batch_last = last;
      send_item(r);
   endtask

   task automatic send_lookup(input logic [ID_W-1:0] id, input logic count);
      req_type r;
      r.action = ACT_LOOKUP;
      r.item_id = id;
      r.belief = BEL_W'($urandom);
      r.initial_hits = HIT_W'($urandom);
      r.count_hit = count;
      r.batch_last = 1'($urandom_range(0, 1));
      send_item(r);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_if.valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity = value;
   endtask

   function automatic logic [ID_W-1:0] rand_id();
      return {$urandom, $urandom};
   endfunction

   task automatic test_basic_merge_lookup();
      send_merge(64'h0, 16'hFFFF, 16'h0, 1'b0);
      send_merge(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 16'hFFFF, 1'b0);
      send_merge(id_pool[0], 16'h8000, 16'h0001, 1'b0);
      send_merge(id_pool[0], 16'h8001, 16'h0005, 1'b0);
      send_lookup(id_pool[0], 1'b1);
      send_merge(id_pool[1], 16'h8000, 16'h0000, 1'b1);
      send_lookup(64'h0, 1'b1);
      send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_lookup(id_pool[5], 1'b1);
   endtask

   task automatic test_capacity_limits();
      write_capacity(5'd0);
      send_merge(id_pool[2], 16'h4000, 16'h0000, 1'b0);
      send_merge(id_pool[3], 16'h1234, 16'h0003, 1'b1);
      send_lookup(id_pool[3], 1'b0);
      write_capacity(5'd31);
      send_merge(id_pool[4], 16'h1234, 16'h0000, 1'b1);
      write_capacity(5'd1);
      send_merge(id_pool[6], 16'h0001, 16'h0000, 1'b1);
      write_capacity(5'd16);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < CACHE_DEPTH; i++)
         send_merge(rand_id(), BEL_W'($urandom), HIT_W'($urandom_range(0, 1)),
                    i == CACHE_DEPTH - 1);
      for (int i = 0; i <= BATCH_DEPTH; i++)
         send_merge(rand_id(), BEL_W'($urandom), HIT_W'($urandom), 1'b0);
      send_merge(tbl_id[3], 16'hFFFF, 16'h0000, 1'b1);
   endtask

   task automatic test_random();
      int batch_len;
      int batches;
      batches = 0;
      while (items_sent < 130) begin
         if (batches % 5 == 4)
            write_capacity(($urandom_range(0, 3) == 0) ? CAP_W'($urandom)
                                                       : CAP_W'($urandom_range(1, 16)));
         batch_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
         for (int i = 0; i < batch_len; i++) begin
            send_merge(($urandom_range(0, 4) == 0) ? rand_id() : id_pool[$urandom_range(0, 23)],
                       ($urandom_range(0, 5) == 0) ? {16{$urandom_range(0, 1) == 1}}
                                                   : BEL_W'($urandom),
                       ($urandom_range(0, 2) == 0) ? HIT_W'($urandom) : 16'h0,
                       i == batch_len - 1);
            if ($urandom_range(0, 5) == 0)
               send_lookup(id_pool[$urandom_range(0, 23)], 1'($urandom_range(0, 1)));
         end
         repeat ($urandom_range(0, 3))
            send_lookup(($urandom_range(0, 5) == 0) ? rand_id() : id_pool[$urandom_range(0, 23)],
                        1'($urandom_range(0, 1)));
         batches++;
      end
   endtask

   initial begin
      errors = 0;
      items_sent = 0;
      tbl_count = 0;
      unused_total = '0;
      insert_total = '0;
      capacity = 5'd16;
      foreach (id_pool[i]) id_pool[i] = rand_id();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_merge_lookup();
      test_capacity_limits();
      test_table_full();
      test_random();
      req_if.valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (IDLE_WAIT) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/brtc_pkg.sv
hdl/brtc_if.sv
hdl/brtc_ctrl.sv
hdl/brtc_datapath.sv
hdl/belief_ranked_topk_cache_core.sv
bench/tb.sv
